// ----- hdl/m4mc_pkg.sv -----
// Package for the 4x4 column matrix multiplier: widths, action codes, stage enable type.
package m4mc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ELEM_W         = 32;
    localparam int ROWS           = 4;
    localparam int COL_W          = $clog2(ROWS);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MULT = 1'b1;

    // Per-stage advance strobes handed from the pipeline control to each lane.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } m4mc_stage_en_t;

endpackage

// ----- hdl/m4mc_dot4_lane.sv -----
// One output row: four products, two adder levels, floor shift and saturation.
module m4mc_dot4_lane #(
    parameter int DATA_WIDTH = m4mc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m4mc_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  m4mc_pkg::m4mc_stage_en_t       en,
    input  logic signed [DATA_WIDTH-1:0]   l_row [m4mc_pkg::ROWS],
    input  logic signed [DATA_WIDTH-1:0]   e_col [m4mc_pkg::ROWS],
    output logic signed [DATA_WIDTH-1:0]   res,
    output logic                           sat
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 2;

    logic signed [PW-1:0]         p_reg    [m4mc_pkg::ROWS];
    logic signed [PW-1:0]         p_next   [m4mc_pkg::ROWS];
    logic signed [PW:0]           pair_reg [2];
    logic signed [PW:0]           pair_next[2];
    logic signed [SW-1:0]         sum_reg;
    logic signed [SW-1:0]         sum_next;
    logic signed [SW-1:0]         shifted;
    logic signed [DATA_WIDTH-1:0] res_reg;
    logic signed [DATA_WIDTH-1:0] res_next;
    logic                         sat_reg;
    logic                         sat_next;
    logic                         in_range;

    always_comb
    begin
        for (int k = 0; k < m4mc_pkg::ROWS; k++)
        begin
            p_next[k] = l_row[k] * e_col[k];
        end
        pair_next[0] = {p_reg[0][PW-1], p_reg[0]} + {p_reg[1][PW-1], p_reg[1]};
        pair_next[1] = {p_reg[2][PW-1], p_reg[2]} + {p_reg[3][PW-1], p_reg[3]};
        sum_next     = {pair_reg[0][PW], pair_reg[0]} + {pair_reg[1][PW], pair_reg[1]};
    end

    // Floor shift, then clamp when the upper bits are not a pure sign extension.
    always_comb
    begin
        shifted  = sum_reg >>> FRAC_BITS;
        in_range = (&shifted[SW-1:DATA_WIDTH-1]) || !(|shifted[SW-1:DATA_WIDTH-1]);
        sat_next = !in_range;
        if (in_range)
        begin
            res_next = shifted[DATA_WIDTH-1:0];
        end
        else if (shifted[SW-1])
        begin
            res_next = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            res_next = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p_reg <= p_next;
        end
        if (en.s2)
        begin
            pair_reg <= pair_next;
        end
        if (en.s3)
        begin
            sum_reg <= sum_next;
        end
        if (en.s4)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// ----- hdl/matrix4_multiply_columns.sv -----
// Top level of the 4x4 column-major fixed-point matrix multiplier.
// Load items (action 0) write one column of the stored left matrix L in the cycle they
// transfer and give no result; multiply items (action 1) carry one column of R and
// return column L*R through the product, pair-sum, full-sum and result registers, with
// one item accepted every cycle while item_ready is high. Sixteen DATA_WIDTH x
// DATA_WIDTH multipliers (one per entry of L) feed four register stages: products,
// pair sums, full sum, then floor shift by FRAC_BITS and saturation to the signed
// DATA_WIDTH range, sign-extended to 32 bits. The flag saturated is set when any row
// was clamped. L is read at the transfer of the multiply item, so a load immediately
// followed by a multiply is seen, and later loads never disturb a multiply in flight.
// Each full stage holds while the one after it is stalled, so result_ready low fills
// bubbles first and then backs up into item_ready. After reset L is all zero.
module matrix4_multiply_columns #(
    parameter int DATA_WIDTH = m4mc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m4mc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               action,
    input  logic [m4mc_pkg::COL_W-1:0]         column,
    input  logic signed [m4mc_pkg::ELEM_W-1:0] elem0,
    input  logic signed [m4mc_pkg::ELEM_W-1:0] elem1,
    input  logic signed [m4mc_pkg::ELEM_W-1:0] elem2,
    input  logic signed [m4mc_pkg::ELEM_W-1:0] elem3,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [m4mc_pkg::COL_W-1:0]         out_column,
    output logic signed [m4mc_pkg::ELEM_W-1:0] res0,
    output logic signed [m4mc_pkg::ELEM_W-1:0] res1,
    output logic signed [m4mc_pkg::ELEM_W-1:0] res2,
    output logic signed [m4mc_pkg::ELEM_W-1:0] res3,
    output logic                               saturated
);

    localparam int Rows  = m4mc_pkg::ROWS;
    localparam int ElemW = m4mc_pkg::ELEM_W;
    localparam int ColW  = m4mc_pkg::COL_W;

    // Stored left matrix, indexed [column][row].
    logic signed [DATA_WIDTH-1:0] l_reg  [Rows][Rows];
    logic signed [DATA_WIDTH-1:0] l_next [Rows][Rows];
    logic signed [DATA_WIDTH-1:0] elem_vec [Rows];
    logic signed [DATA_WIDTH-1:0] l_row    [Rows][Rows];   // [row][column]
    logic signed [DATA_WIDTH-1:0] lane_res [Rows];
    logic [Rows-1:0]              lane_sat;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic                   v1_next, v2_next, v3_next, v4_next;
    logic [ColW-1:0]        col1_reg, col2_reg, col3_reg, col4_reg;
    logic [ColW-1:0]        col1_next, col2_next, col3_next, col4_next;
    logic                   adv1, adv2, adv3, adv4;
    logic                   in_xfer;
    logic                   load_xfer;
    logic                   mult_xfer;
    m4mc_pkg::m4mc_stage_en_t stage_en;

    assign elem_vec[0] = elem0[DATA_WIDTH-1:0];
    assign elem_vec[1] = elem1[DATA_WIDTH-1:0];
    assign elem_vec[2] = elem2[DATA_WIDTH-1:0];
    assign elem_vec[3] = elem3[DATA_WIDTH-1:0];

    // A stage advances when it is empty or the stage after it advances.
    assign adv4       = !v4_reg || result_ready;
    assign adv3       = !v3_reg || adv4;
    assign adv2       = !v2_reg || adv3;
    assign adv1       = !v1_reg || adv2;
    assign item_ready = adv1;

    assign in_xfer   = item_valid && item_ready;
    assign load_xfer = in_xfer && (action == m4mc_pkg::ACT_LOAD);
    assign mult_xfer = in_xfer && (action == m4mc_pkg::ACT_MULT);

    assign stage_en = '{s1: adv1, s2: adv2, s3: adv3, s4: adv4};

    // Write the loaded column of L.
    always_comb
    begin
        l_next = l_reg;
        if (load_xfer)
        begin
            for (int r = 0; r < Rows; r++)
            begin
                l_next[column][r] = elem_vec[r];
            end
        end
    end

    // Valid bits and column index travel with the data; drop loads at the entry.
    always_comb
    begin
        v1_next   = v1_reg;
        col1_next = col1_reg;
        v2_next   = v2_reg;
        col2_next = col2_reg;
        v3_next   = v3_reg;
        col3_next = col3_reg;
        v4_next   = v4_reg;
        col4_next = col4_reg;
        if (adv1)
        begin
            v1_next   = mult_xfer;
            col1_next = column;
        end
        if (adv2)
        begin
            v2_next   = v1_reg;
            col2_next = col1_reg;
        end
        if (adv3)
        begin
            v3_next   = v2_reg;
            col3_next = col2_reg;
        end
        if (adv4)
        begin
            v4_next   = v3_reg;
            col4_next = col3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < Rows; c++)
            begin
                for (int r = 0; r < Rows; r++)
                begin
                    l_reg[c][r] <= '0;
                end
            end
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            l_reg  <= l_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col1_reg <= col1_next;
        col2_reg <= col2_next;
        col3_reg <= col3_next;
        col4_reg <= col4_next;
    end

    // One lane per output row; lane r sees row r of L against the incoming column.
    for (genvar r = 0; r < Rows; r++)
    begin : g_lane
        for (genvar k = 0; k < Rows; k++)
        begin : g_tap
            assign l_row[r][k] = l_reg[k][r];
        end

        m4mc_dot4_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .en    (stage_en),
            .l_row (l_row[r]),
            .e_col (elem_vec),
            .res   (lane_res[r]),
            .sat   (lane_sat[r])
        );
    end

    assign result_valid = v4_reg;
    assign out_column   = col4_reg;
    assign res0         = ElemW'(lane_res[0]);
    assign res1         = ElemW'(lane_res[1]);
    assign res2         = ElemW'(lane_res[2]);
    assign res3         = ElemW'(lane_res[3]);
    assign saturated    = |lane_sat;

    localparam logic signed [ElemW-1:0] SatMax =
        ElemW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [ElemW-1:0] SatMin =
        ElemW'(signed'({1'b1, {(DATA_WIDTH-1){1'b0}}}));

    // A multiply transfer always occupies the first stage on the next cycle.
    a_mult_enters: assert property (@(posedge clk) disable iff (!rst_n)
        mult_xfer |=> v1_reg)
        else $error("multiply item did not enter the pipeline");

    // A full stage that cannot advance keeps its item and column.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !adv3) |=> (v3_reg && $stable(col3_reg)))
        else $error("stalled item lost in stage three");

    // A load writes row 0 of the addressed column.
    a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
        load_xfer |=> (l_reg[$past(column)][0] == $past(elem_vec[0])))
        else $error("load did not update the left matrix");

    // A saturated result carries a clamp value in some row.
    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            (res0 == SatMax || res0 == SatMin || res1 == SatMax || res1 == SatMin ||
             res2 == SatMax || res2 == SatMin || res3 == SatMax || res3 == SatMin))
        else $error("saturation flag without a clamped row");

endmodule
